// ===== hw/rtl/i2cm_pkg.sv =====
`timescale 1ns / 1ps

package i2cm_pkg;

  // Ticks per bus step after reset
  localparam logic [7:0] PHASE_TICKS_RESET = 8'd48;

  // Index of the acknowledge slot within a byte
  localparam logic [3:0] ACK_SLOT = 4'd8;

  // Transaction kinds
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // One input item: one clock tick of the sequencer
  typedef struct packed {
    logic        go;
    logic        opcode;
    logic [6:0]  device_address;
    logic [7:0]  register_address;
    logic [15:0] write_data;
    logic        sda_sample;
  } in_item_t;

  // One result item: bus drive and status for that tick
  typedef struct packed {
    logic        scl_level;
    logic        sda_pull_low;
    logic        busy_res;
    logic        done_res;
    logic [15:0] read_data;
    logic        nack_seen;
  } out_item_t;

endpackage

// ===== hw/rtl/i2cm_seq.sv =====
`timescale 1ns / 1ps

module i2cm_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  i2cm_pkg::in_item_t  item,
  input  logic [7:0]          phase_ticks,
  output i2cm_pkg::out_item_t res
);

  typedef enum logic [4:0] {
    S_IDLE        = 5'd0,
    S_START_SETUP = 5'd1,
    S_START_HOLD  = 5'd2,
    S_ADDR_W_LO   = 5'd3,
    S_ADDR_W_HI   = 5'd4,
    S_REG_LO      = 5'd5,
    S_REG_HI      = 5'd6,
    S_DATA_H_LO   = 5'd7,
    S_DATA_H_HI   = 5'd8,
    S_DATA_L_LO   = 5'd9,
    S_DATA_L_HI   = 5'd10,
    S_ADDR_R_LO   = 5'd11,
    S_ADDR_R_HI   = 5'd12,
    S_READ1_LO    = 5'd13,
    S_READ1_HI    = 5'd14,
    S_READ2_LO    = 5'd15,
    S_READ2_HI    = 5'd16,
    S_RS_LOW      = 5'd17,
    S_RS_HIGH     = 5'd18,
    S_RS_HOLD     = 5'd19,
    S_STOP_LOW    = 5'd20,
    S_STOP_HIGH   = 5'd21,
    S_STOP_END    = 5'd22
  } step_t;

  step_t       step, step_next;
  logic [7:0]  phase_counter, phase_counter_next;
  logic [3:0]  bit_counter, bit_counter_next;
  logic [7:0]  shift_register, shift_register_next;
  logic        req_opcode, req_opcode_next;
  logic [6:0]  req_device, req_device_next;
  logic [7:0]  req_register, req_register_next;
  logic [15:0] req_data, req_data_next;
  logic [15:0] received_word, received_word_next;
  logic        nack_flag, nack_flag_next;

  // Next state and this tick's result
  always_comb begin
    step_t      s;
    step_t      target;
    logic [4:0] base;
    logic       is_byte;
    logic       rx;
    logic       step_end;
    logic [8:0] limit;
    logic [8:0] count_inc;
    logic       scl;
    logic       pull;
    logic       busy;
    logic       done;

    step_next           = step;
    phase_counter_next  = phase_counter;
    bit_counter_next    = bit_counter;
    shift_register_next = shift_register;
    req_opcode_next     = req_opcode;
    req_device_next     = req_device;
    req_register_next   = req_register;
    req_data_next       = req_data;
    received_word_next  = received_word;
    nack_flag_next      = nack_flag;
    scl    = 1'b1;
    pull   = 1'b0;
    busy   = 1'b0;
    done   = 1'b0;
    target = S_IDLE;

    // Codes past the stop sequence fall back to idle
    s = (step > S_STOP_END) ? S_IDLE : step;

    // Latch a request on the go tick
    if (s == S_IDLE && item.go) begin
      req_opcode_next    = item.opcode;
      req_device_next    = item.device_address;
      req_register_next  = item.register_address;
      req_data_next      = item.write_data;
      received_word_next = '0;
      nack_flag_next     = 1'b0;
      phase_counter_next = '0;
      bit_counter_next   = '0;
      s                  = S_START_SETUP;
    end
    step_next = s;

    is_byte   = (s >= S_ADDR_W_LO) && (s <= S_READ2_HI);
    base      = s[0] ? 5'(s) : 5'(s) - 5'd1;
    rx        = is_byte && (base >= 5'(S_READ1_LO));
    limit     = (phase_ticks == 8'd0) ? 9'd256 : {1'b0, phase_ticks};
    count_inc = {1'b0, phase_counter_next} + 9'd1;
    step_end  = count_inc >= limit;

    if (s != S_IDLE) begin
      busy = 1'b1;

      // Bus drive for the current step
      if (is_byte) begin
        scl = (5'(s) == base) ? 1'b0 : 1'b1;
        if (bit_counter_next < i2cm_pkg::ACK_SLOT) begin
          pull = rx ? 1'b0 : ~shift_register[7];
        end else begin
          pull = rx && (base == 5'(S_READ1_LO));
        end
      end else begin
        case (s)
          S_START_SETUP: begin scl = 1'b1; pull = 1'b0; end
          S_START_HOLD:  begin scl = 1'b1; pull = 1'b1; end
          S_RS_LOW:      begin scl = 1'b0; pull = 1'b0; end
          S_RS_HIGH:     begin scl = 1'b1; pull = 1'b0; end
          S_RS_HOLD:     begin scl = 1'b1; pull = 1'b1; end
          S_STOP_LOW:    begin scl = 1'b0; pull = 1'b1; end
          S_STOP_HIGH:   begin scl = 1'b1; pull = 1'b1; end
          default:       begin scl = 1'b1; pull = 1'b0; end
        endcase
      end

      // Step timing and sequencing
      if (!step_end) begin
        phase_counter_next = count_inc[7:0];
      end else begin
        phase_counter_next = '0;
        if (is_byte) begin
          if (5'(s) == base) begin
            step_next = step_t'(base + 5'd1);
          end else if (bit_counter_next < i2cm_pkg::ACK_SLOT) begin
            if (rx) begin
              received_word_next = {received_word[14:0], item.sda_sample};
            end else begin
              shift_register_next = {shift_register[6:0], 1'b0};
            end
            bit_counter_next = bit_counter_next + 4'd1;
            step_next        = step_t'(base);
          end else begin
            if (!rx && item.sda_sample) begin
              nack_flag_next = 1'b1;
            end
            unique case (base)
              5'(S_ADDR_W_LO): target = S_REG_LO;
              5'(S_REG_LO):    target = (req_opcode == i2cm_pkg::OP_READ) ?
                                        S_RS_LOW : S_DATA_H_LO;
              5'(S_DATA_H_LO): target = S_DATA_L_LO;
              5'(S_ADDR_R_LO): target = S_READ1_LO;
              5'(S_READ1_LO):  target = S_READ2_LO;
              default:         target = S_STOP_LOW;
            endcase
          end
        end else begin
          unique case (s)
            S_START_SETUP: step_next = S_START_HOLD;
            S_START_HOLD:  target    = S_ADDR_W_LO;
            S_RS_LOW:      step_next = S_RS_HIGH;
            S_RS_HIGH:     step_next = S_RS_HOLD;
            S_RS_HOLD:     target    = S_ADDR_R_LO;
            S_STOP_LOW:    step_next = S_STOP_HIGH;
            S_STOP_HIGH:   step_next = S_STOP_END;
            default: begin
              step_next = S_IDLE;
              done      = 1'b1;
            end
          endcase
        end

        // Entering a byte loads the byte to send
        if (target != S_IDLE) begin
          step_next = target;
          if (target >= S_ADDR_W_LO && target <= S_READ2_HI) begin
            bit_counter_next = '0;
            unique case (target)
              S_ADDR_W_LO: shift_register_next = {req_device, 1'b0};
              S_REG_LO:    shift_register_next = req_register;
              S_DATA_H_LO: shift_register_next = req_data[15:8];
              S_DATA_L_LO: shift_register_next = req_data[7:0];
              S_ADDR_R_LO: shift_register_next = {req_device, 1'b1};
              default:     shift_register_next = '0;
            endcase
          end
        end
      end
    end

    res.scl_level    = scl;
    res.sda_pull_low = pull;
    res.busy_res     = busy;
    res.done_res     = done;
    res.read_data    = received_word_next;
    res.nack_seen    = nack_flag_next;
  end

  // Sequencer state, updated once per accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      step           <= S_IDLE;
      phase_counter  <= '0;
      bit_counter    <= '0;
      shift_register <= '0;
      received_word  <= '0;
      nack_flag      <= 1'b0;
    end else if (advance) begin
      step           <= step_next;
      phase_counter  <= phase_counter_next;
      bit_counter    <= bit_counter_next;
      shift_register <= shift_register_next;
      received_word  <= received_word_next;
      nack_flag      <= nack_flag_next;
    end
  end

  // Latched request, only read after a go tick
  always_ff @(posedge clk) begin
    if (advance) begin
      req_opcode   <= req_opcode_next;
      req_device   <= req_device_next;
      req_register <= req_register_next;
      req_data     <= req_data_next;
    end
  end

`ifndef SYNTH
  a_done_to_idle: assert property (@(posedge clk) disable iff (rst)
    advance && res.done_res |=> step == S_IDLE)
    else $error("sequencer not idle after done");

  a_go_starts: assert property (@(posedge clk) disable iff (rst)
    advance && step == S_IDLE && item.go |=> step != S_IDLE)
    else $error("go tick did not start a transaction");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(step) && $stable(phase_counter) && $stable(received_word))
    else $error("state moved without an accepted item");

  a_bit_range: assert property (@(posedge clk) disable iff (rst)
    bit_counter <= i2cm_pkg::ACK_SLOT)
    else $error("bit counter beyond acknowledge slot");

  a_idle_released: assert property (@(posedge clk) disable iff (rst)
    advance && step == S_IDLE && !item.go |-> res.scl_level && !res.sda_pull_low)
    else $error("bus driven while idle");
`endif

endmodule

// ===== hw/rtl/i2cm_out_reg.sv =====
`timescale 1ns / 1ps

module i2cm_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  i2cm_pkg::out_item_t res,
  input  logic                load,
  output logic                can_load,
  output logic                out_valid,
  input  logic                out_ready,
  output i2cm_pkg::out_item_t out_item
);

  // Space when empty or when the held item leaves this cycle
  assign can_load = !out_valid || out_ready;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_item <= res;
    end
  end

endmodule

// ===== hw/rtl/i2c_master_register_access.sv =====
`timescale 1ns / 1ps

// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid / in_ready   | in_item  (one bus tick)
// out     | output    | out_valid / out_ready | out_item (drive and status)
// cfg     | input     | cfg_valid / cfg_ready | cfg_data (phase_ticks)
//
// One item is taken per cycle while in_ready is high; its result is held
// in the output register. The sequencer state advances only on accepted
// items. When out_ready is low with a result held, in_ready drops until it
// is taken. Synchronous reset returns the sequencer to idle and phase_ticks
// to 48. cfg_ready is always high; a write takes effect from the next item.

module i2c_master_register_access (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  i2cm_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output i2cm_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);

  logic                phase_ticks;
  logic [7:0]          phase_ticks_q;
  logic                advance;
  i2cm_pkg::out_item_t res;

  assign cfg_ready   = 1'b1;
  assign phase_ticks = cfg_valid && cfg_ready;
  assign advance     = in_valid && in_ready;

  // Bus rate register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks_q <= i2cm_pkg::PHASE_TICKS_RESET;
    end else if (phase_ticks) begin
      phase_ticks_q <= cfg_data;
    end
  end

  i2cm_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .item        (in_item),
    .phase_ticks (phase_ticks_q),
    .res         (res)
  );

  i2cm_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .res       (res),
    .load      (advance),
    .can_load  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
